/* src/gws_pkg.sv */
`timescale 1ns / 1ps

package gws_pkg;

    // Input sample and group count widths
    localparam int VALUE_BITS = 16;
    localparam int COUNT_BITS = 16;
    localparam logic [17:0] COUNT_MAX = 18'((1 << COUNT_BITS) - 1);

    // Closed-group queue between front and back
    localparam int QDEPTH = 2;
    localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    // Shared shift-add multiplier
    localparam int WIDE  = 256;
    localparam int MB    = 128;
    localparam int NBW   = 7;

    // Multiplier bit counts for each operand kind (two's complement widths)
    localparam logic [NBW-1:0] NB_COUNT = 7'd18;
    localparam logic [NBW-1:0] NB_SUM1  = 7'd33;
    localparam logic [NBW-1:0] NB_THIRD = 7'd100;
    localparam logic [NBW-1:0] NB_CUBE  = 7'd50;
    localparam logic [NBW-1:0] NB_SCALE = 7'd80;

    // Division and square root
    localparam int QUO_BITS = 62;
    localparam logic [5:0] DIV_LAST_STEP  = 6'd61;
    localparam logic [5:0] SQRT_LAST_STEP = 6'd31;
    localparam logic [63:0] SQ_ONE_INIT   = 64'h4000_0000_0000_0000;

    localparam logic [31:0] SKEW_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SKEW_NEG_MAX = 32'h8000_0000;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FEW  = 2'd1,
        ST_FLAT = 2'd2,
        ST_OVF  = 2'd3
    } status_t;

    // Snapshot of one closed group
    typedef struct packed {
        logic        [31:0] key;
        logic        [16:0] count;
        logic signed [32:0] s1;
        logic signed [47:0] s2;
        logic signed [62:0] s3;
        logic               ovf;
    } snap_t;

    typedef struct packed {
        logic            start;
        logic [WIDE-1:0] a;
        logic [MB-1:0]   b;
        logic [NBW-1:0]  nb;
    } mul_req_t;

    typedef struct packed {
        logic            busy;
        logic            done;
        logic [WIDE-1:0] prod;
    } mul_rsp_t;

    typedef enum logic [4:0] {
        BS_IDLE,
        BS_CHECK,
        BS_P,
        BS_T,
        BS_A,
        BS_ZERO,
        BS_C,
        BS_W,
        BS_U,
        BS_V,
        BS_B,
        BS_ABS,
        BS_B2,
        BS_M2,
        BS_M3,
        BS_NN,
        BS_E,
        BS_E2,
        BS_D,
        BS_DIV0,
        BS_DIV,
        BS_SQRT,
        BS_OUT
    } bstate_t;

endpackage

/* src/gws_front.sv */
`timescale 1ns / 1ps

module gws_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [31:0]         group_key,
    input  logic signed [15:0]  sample_value,
    input  logic [15:0]         repeat_weight,
    input  logic                flush_end,
    output logic                push,
    output gws_pkg::snap_t      push_data,
    input  logic                q_full
);

    // Classification state: the group as seen at the input
    logic        open_reg;
    logic [31:0] key_reg;

    // Stage 1
    logic                v1_reg;
    logic [31:0]         key1_reg;
    logic [15:0]         w1_reg;
    logic signed [15:0]  x1_reg;
    logic signed [32:0]  wx1_reg;
    logic signed [31:0]  xx1_reg;
    logic                emit1_reg;
    logic                new1_reg;
    logic                flush1_reg;

    // Stage 2
    logic                v2_reg;
    logic [31:0]         key2_reg;
    logic [15:0]         w2_reg;
    logic signed [32:0]  wx2_reg;
    logic signed [47:0]  p2_reg;
    logic signed [62:0]  p3_reg;
    logic                emit2_reg;
    logic                new2_reg;
    logic                flush2_reg;

    // Accumulator for the open group
    logic [31:0]         acc_key_reg;
    logic [16:0]         acc_cnt_reg;
    logic signed [32:0]  acc_s1_reg;
    logic signed [47:0]  acc_s2_reg;
    logic signed [62:0]  acc_s3_reg;
    logic                acc_ovf_reg;

    logic                adv;
    logic                take;
    logic                is_new;
    logic                is_emit;
    logic signed [15:0]  x_c;
    logic signed [32:0]  wx_c;
    logic signed [31:0]  xx_c;
    logic signed [48:0]  p2_c;
    logic signed [64:0]  p3_c;
    logic [16:0]         base_cnt;
    logic signed [32:0]  base_s1;
    logic signed [47:0]  base_s2;
    logic signed [62:0]  base_s3;
    logic                base_ovf;
    logic [17:0]         sum_cnt;
    logic                ovf_hit;

    // Whole pipe moves together; it holds only when a close meets a full queue
    assign adv      = !(v2_reg && emit2_reg && q_full);
    assign in_stall = !adv;
    assign take     = in_valid && adv;

    // Classify the incoming request against the open group
    assign is_new  = !flush_end && (!open_reg || (group_key != key_reg));
    assign is_emit = open_reg && (flush_end || (group_key != key_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            key_reg  <= 32'd0;
        end
        else if (take)
        begin
            if (flush_end)
            begin
                open_reg <= 1'b0;
            end
            else
            begin
                open_reg <= 1'b1;
                key_reg  <= group_key;
            end
        end
    end

    // First products
    assign x_c  = 16'($signed(sample_value[gws_pkg::VALUE_BITS-1:0]));
    assign wx_c = $signed({1'b0, repeat_weight}) * x_c;
    assign xx_c = x_c * x_c;

    // Second products
    assign p2_c = wx1_reg * x1_reg;
    assign p3_c = wx1_reg * xx1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            key1_reg   <= group_key;
            w1_reg     <= repeat_weight;
            x1_reg     <= x_c;
            wx1_reg    <= wx_c;
            xx1_reg    <= xx_c;
            emit1_reg  <= is_emit;
            new1_reg   <= is_new;
            flush1_reg <= flush_end;

            key2_reg   <= key1_reg;
            w2_reg     <= w1_reg;
            wx2_reg    <= wx1_reg;
            p2_reg     <= p2_c[47:0];
            p3_reg     <= p3_c[62:0];
            emit2_reg  <= emit1_reg;
            new2_reg   <= new1_reg;
            flush2_reg <= flush1_reg;
        end
    end

    // Accumulate: a new group starts from zero sums
    assign base_cnt = new2_reg ? 17'd0 : acc_cnt_reg;
    assign base_s1  = new2_reg ? 33'sd0 : acc_s1_reg;
    assign base_s2  = new2_reg ? 48'sd0 : acc_s2_reg;
    assign base_s3  = new2_reg ? 63'sd0 : acc_s3_reg;
    assign base_ovf = new2_reg ? 1'b0 : acc_ovf_reg;
    assign sum_cnt  = {1'b0, base_cnt} + {2'b00, w2_reg};
    assign ovf_hit  = sum_cnt > gws_pkg::COUNT_MAX;

    always_ff @(posedge clk)
    begin
        if (adv && v2_reg && !flush2_reg)
        begin
            acc_key_reg <= key2_reg;
            if (base_ovf || ovf_hit)
            begin
                acc_cnt_reg <= base_cnt;
                acc_s1_reg  <= base_s1;
                acc_s2_reg  <= base_s2;
                acc_s3_reg  <= base_s3;
                acc_ovf_reg <= 1'b1;
            end
            else
            begin
                acc_cnt_reg <= sum_cnt[16:0];
                acc_s1_reg  <= base_s1 + wx2_reg;
                acc_s2_reg  <= base_s2 + p2_reg;
                acc_s3_reg  <= base_s3 + p3_reg;
                acc_ovf_reg <= 1'b0;
            end
        end
    end

    // Hand the closed group to the queue
    assign push            = v2_reg && emit2_reg && adv;
    assign push_data.key   = acc_key_reg;
    assign push_data.count = acc_cnt_reg;
    assign push_data.s1    = acc_s1_reg;
    assign push_data.s2    = acc_s2_reg;
    assign push_data.s3    = acc_s3_reg;
    assign push_data.ovf   = acc_ovf_reg;

endmodule

/* src/gws_queue.sv */
`timescale 1ns / 1ps

module gws_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  gws_pkg::snap_t push_data,
    output logic           full,
    input  logic           pop,
    output gws_pkg::snap_t head,
    output logic           nonempty
);

    gws_pkg::snap_t          mem_reg [gws_pkg::QDEPTH];
    logic [gws_pkg::QAW-1:0] wr_ptr_reg;
    logic [gws_pkg::QAW-1:0] rd_ptr_reg;
    logic [gws_pkg::QAW:0]   count_reg;

    assign full     = count_reg == (gws_pkg::QAW+1)'(gws_pkg::QDEPTH);
    assign nonempty = count_reg != '0;
    assign head     = mem_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == gws_pkg::QAW'(gws_pkg::QDEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == gws_pkg::QAW'(gws_pkg::QDEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* src/gws_mul.sv */
`timescale 1ns / 1ps

module gws_mul
(
    input  logic              clk,
    input  logic              rst_n,
    input  gws_pkg::mul_req_t req,
    output gws_pkg::mul_rsp_t rsp
);

    logic                     busy_reg;
    logic                     done_reg;
    logic [gws_pkg::WIDE-1:0] acc_reg;
    logic [gws_pkg::WIDE-1:0] sh_reg;
    logic [gws_pkg::MB-1:0]   bb_reg;
    logic [gws_pkg::NBW-1:0]  cnt_reg;
    logic [gws_pkg::WIDE-1:0] term;
    logic                     load;

    assign load = req.start && !busy_reg;
    assign term = bb_reg[0] ? sh_reg : '0;

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg && (cnt_reg == '0))
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // One multiplier bit a cycle; the top bit carries negative weight
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            acc_reg <= '0;
            sh_reg  <= req.a;
            bb_reg  <= req.b;
            cnt_reg <= req.nb - 1'b1;
        end
        else if (busy_reg)
        begin
            acc_reg <= (cnt_reg == '0) ? acc_reg - term : acc_reg + term;
            sh_reg  <= {sh_reg[gws_pkg::WIDE-2:0], 1'b0};
            bb_reg  <= {1'b0, bb_reg[gws_pkg::MB-1:1]};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

/* src/gws_back.sv */
`timescale 1ns / 1ps

module gws_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  gws_pkg::snap_t    head,
    input  logic              nonempty,
    output logic              pop,
    output gws_pkg::mul_req_t mul_req,
    input  gws_pkg::mul_rsp_t mul_rsp,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [31:0]       result_key,
    output logic [31:0]       skewness_value,
    output logic [1:0]        status_code
);

    gws_pkg::bstate_t state_reg;
    gws_pkg::bstate_t state_next;

    // Snapshot of the group being worked on
    logic [31:0]         key_reg;
    logic [16:0]         n_reg;
    logic signed [32:0]  s1_reg;
    logic signed [47:0]  s2_reg;
    logic signed [62:0]  s3_reg;
    logic                ovf_reg;

    gws_pkg::status_t    status_reg;
    logic                neg_reg;
    logic                sat_reg;

    // Wide working registers
    logic [255:0]        rp_reg;
    logic [255:0]        rx_reg;
    logic [255:0]        ra_reg;
    logic [255:0]        rb_reg;
    logic [255:0]        rm_reg;
    logic [255:0]        re_reg;

    // Division and square root
    logic [256:0]        div_r_reg;
    logic [61:0]         div_lo_reg;
    logic [61:0]         q_reg;
    logic [63:0]         sq_res_reg;
    logic [63:0]         sq_one_reg;
    logic [5:0]          step_reg;

    // Output register
    logic                out_valid_reg;
    logic [31:0]         result_key_reg;
    logic [31:0]         skew_reg;
    logic [1:0]          status_out_reg;

    logic                is_mul;
    logic                out_load;
    logic [255:0]        s1_wide;
    logic [255:0]        s2_wide;
    logic [255:0]        s3_wide;
    logic [255:0]        n_wide;
    logic [16:0]         m1;
    logic [255:0]        m1_wide;
    logic [127:0]        s1_narrow;
    logic [127:0]        n_narrow;
    logic [127:0]        m1_narrow;
    logic [256:0]        div_r0;
    logic [256:0]        den_ext;
    logic [256:0]        r_sh;
    logic [63:0]         sq_try;
    logic [63:0]         q_ext;
    logic [31:0]         skew_c;

    assign s1_wide   = {{223{s1_reg[32]}}, s1_reg};
    assign s2_wide   = {{208{s2_reg[47]}}, s2_reg};
    assign s3_wide   = {{193{s3_reg[62]}}, s3_reg};
    assign n_wide    = {239'd0, n_reg};
    assign m1        = n_reg - 17'd1;
    assign m1_wide   = {239'd0, m1};
    assign s1_narrow = {{95{s1_reg[32]}}, s1_reg};
    assign n_narrow  = {111'd0, n_reg};
    assign m1_narrow = {111'd0, m1};

    assign div_r0  = {31'd0, rb_reg[255:30]};
    assign den_ext = {1'b0, rx_reg};
    assign r_sh    = {div_r_reg[255:0], div_lo_reg[61]};
    assign sq_try  = sq_res_reg + sq_one_reg;
    assign q_ext   = {2'b00, q_reg};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gws_pkg::BS_IDLE:
            begin
                if (nonempty)
                begin
                    state_next = gws_pkg::BS_CHECK;
                end
            end
            gws_pkg::BS_CHECK:
            begin
                if (ovf_reg || (n_reg < 17'd2))
                begin
                    state_next = gws_pkg::BS_OUT;
                end
                else
                begin
                    state_next = gws_pkg::BS_P;
                end
            end
            gws_pkg::BS_P:  if (mul_rsp.done) state_next = gws_pkg::BS_T;
            gws_pkg::BS_T:  if (mul_rsp.done) state_next = gws_pkg::BS_A;
            gws_pkg::BS_A:  state_next = gws_pkg::BS_ZERO;
            gws_pkg::BS_ZERO:
            begin
                if (ra_reg == '0)
                begin
                    state_next = gws_pkg::BS_OUT;
                end
                else
                begin
                    state_next = gws_pkg::BS_C;
                end
            end
            gws_pkg::BS_C:   state_next = gws_pkg::BS_W;
            gws_pkg::BS_W:   if (mul_rsp.done) state_next = gws_pkg::BS_U;
            gws_pkg::BS_U:   if (mul_rsp.done) state_next = gws_pkg::BS_V;
            gws_pkg::BS_V:   if (mul_rsp.done) state_next = gws_pkg::BS_B;
            gws_pkg::BS_B:   state_next = gws_pkg::BS_ABS;
            gws_pkg::BS_ABS: state_next = gws_pkg::BS_B2;
            gws_pkg::BS_B2:  if (mul_rsp.done) state_next = gws_pkg::BS_M2;
            gws_pkg::BS_M2:  if (mul_rsp.done) state_next = gws_pkg::BS_M3;
            gws_pkg::BS_M3:  if (mul_rsp.done) state_next = gws_pkg::BS_NN;
            gws_pkg::BS_NN:  if (mul_rsp.done) state_next = gws_pkg::BS_E;
            gws_pkg::BS_E:   if (mul_rsp.done) state_next = gws_pkg::BS_E2;
            gws_pkg::BS_E2:  if (mul_rsp.done) state_next = gws_pkg::BS_D;
            gws_pkg::BS_D:   if (mul_rsp.done) state_next = gws_pkg::BS_DIV0;
            gws_pkg::BS_DIV0:
            begin
                if (div_r0 >= den_ext)
                begin
                    state_next = gws_pkg::BS_OUT;
                end
                else
                begin
                    state_next = gws_pkg::BS_DIV;
                end
            end
            gws_pkg::BS_DIV:
            begin
                if (step_reg == '0)
                begin
                    state_next = gws_pkg::BS_SQRT;
                end
            end
            gws_pkg::BS_SQRT:
            begin
                if (step_reg == '0)
                begin
                    state_next = gws_pkg::BS_OUT;
                end
            end
            gws_pkg::BS_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = gws_pkg::BS_IDLE;
                end
            end
            default: state_next = gws_pkg::BS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gws_pkg::BS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Outputs of the sequencer: queue pop and multiplier operands
    always_comb
    begin
        pop        = (state_reg == gws_pkg::BS_IDLE) && nonempty;
        out_load   = (state_reg == gws_pkg::BS_OUT) && (!out_valid_reg || !out_stall);
        is_mul     = 1'b1;
        mul_req.a  = '0;
        mul_req.b  = '0;
        mul_req.nb = gws_pkg::NB_COUNT;
        unique case (state_reg)
            gws_pkg::BS_P:
            begin
                mul_req.a  = s1_wide;
                mul_req.b  = s1_narrow;
                mul_req.nb = gws_pkg::NB_SUM1;
            end
            gws_pkg::BS_T:
            begin
                mul_req.a  = s2_wide;
                mul_req.b  = n_narrow;
            end
            gws_pkg::BS_W:
            begin
                mul_req.a  = rx_reg;
                mul_req.b  = s1_narrow;
                mul_req.nb = gws_pkg::NB_SUM1;
            end
            gws_pkg::BS_U:
            begin
                mul_req.a  = s3_wide;
                mul_req.b  = n_narrow;
            end
            gws_pkg::BS_V:
            begin
                mul_req.a  = rx_reg;
                mul_req.b  = n_narrow;
            end
            gws_pkg::BS_B2:
            begin
                mul_req.a  = rb_reg;
                mul_req.b  = rb_reg[127:0];
                mul_req.nb = gws_pkg::NB_THIRD;
            end
            gws_pkg::BS_M2:
            begin
                mul_req.a  = m1_wide;
                mul_req.b  = m1_narrow;
            end
            gws_pkg::BS_M3:
            begin
                mul_req.a  = rm_reg;
                mul_req.b  = m1_narrow;
            end
            gws_pkg::BS_NN:
            begin
                mul_req.a  = rb_reg;
                mul_req.b  = rm_reg[127:0];
                mul_req.nb = gws_pkg::NB_CUBE;
            end
            gws_pkg::BS_E:
            begin
                mul_req.a  = ra_reg;
                mul_req.b  = n_narrow;
            end
            gws_pkg::BS_E2:
            begin
                mul_req.a  = re_reg;
                mul_req.b  = re_reg[127:0];
                mul_req.nb = gws_pkg::NB_SCALE;
            end
            gws_pkg::BS_D:
            begin
                mul_req.a  = rx_reg;
                mul_req.b  = re_reg[127:0];
                mul_req.nb = gws_pkg::NB_SCALE;
            end
            default:
            begin
                is_mul = 1'b0;
            end
        endcase
        mul_req.start = is_mul && !mul_rsp.busy && !mul_rsp.done;
    end

    // Datapath: power-sum algebra, long division, square root
    always_ff @(posedge clk)
    begin
        case (state_reg)
            gws_pkg::BS_IDLE:
            begin
                if (nonempty)
                begin
                    key_reg    <= head.key;
                    n_reg      <= head.count;
                    s1_reg     <= head.s1;
                    s2_reg     <= head.s2;
                    s3_reg     <= head.s3;
                    ovf_reg    <= head.ovf;
                    status_reg <= gws_pkg::ST_OK;
                    neg_reg    <= 1'b0;
                    sat_reg    <= 1'b0;
                end
            end
            gws_pkg::BS_CHECK:
            begin
                if (ovf_reg)
                begin
                    status_reg <= gws_pkg::ST_OVF;
                end
                else if (n_reg < 17'd2)
                begin
                    status_reg <= gws_pkg::ST_FEW;
                end
            end
            gws_pkg::BS_P:  if (mul_rsp.done) rp_reg <= mul_rsp.prod;
            gws_pkg::BS_T:  if (mul_rsp.done) rx_reg <= mul_rsp.prod;
            gws_pkg::BS_A:  ra_reg <= rx_reg - rp_reg;
            gws_pkg::BS_ZERO:
            begin
                if (ra_reg == '0)
                begin
                    status_reg <= gws_pkg::ST_FLAT;
                end
            end
            // 3A + S1^2 = 3 n S2 - 2 S1^2
            gws_pkg::BS_C:  rx_reg <= {ra_reg[254:0], 1'b0} + ra_reg + rp_reg;
            gws_pkg::BS_W:  if (mul_rsp.done) rb_reg <= mul_rsp.prod;
            gws_pkg::BS_U:  if (mul_rsp.done) rx_reg <= mul_rsp.prod;
            gws_pkg::BS_V:  if (mul_rsp.done) rx_reg <= mul_rsp.prod;
            gws_pkg::BS_B:  rb_reg <= rx_reg - rb_reg;
            gws_pkg::BS_ABS:
            begin
                neg_reg <= rb_reg[255];
                if (rb_reg[255])
                begin
                    rb_reg <= '0 - rb_reg;
                end
            end
            gws_pkg::BS_B2: if (mul_rsp.done) rb_reg <= mul_rsp.prod;
            gws_pkg::BS_M2: if (mul_rsp.done) rm_reg <= mul_rsp.prod;
            gws_pkg::BS_M3: if (mul_rsp.done) rm_reg <= mul_rsp.prod;
            gws_pkg::BS_NN: if (mul_rsp.done) rb_reg <= mul_rsp.prod;
            gws_pkg::BS_E:  if (mul_rsp.done) re_reg <= mul_rsp.prod;
            gws_pkg::BS_E2: if (mul_rsp.done) rx_reg <= mul_rsp.prod;
            gws_pkg::BS_D:  if (mul_rsp.done) rx_reg <= mul_rsp.prod;
            gws_pkg::BS_DIV0:
            begin
                div_r_reg  <= div_r0;
                div_lo_reg <= {rb_reg[29:0], 32'd0};
                q_reg      <= '0;
                step_reg   <= gws_pkg::DIV_LAST_STEP;
                sat_reg    <= div_r0 >= den_ext;
            end
            gws_pkg::BS_DIV:
            begin
                if (r_sh >= den_ext)
                begin
                    div_r_reg <= r_sh - den_ext;
                    q_reg     <= {q_reg[60:0], 1'b1};
                end
                else
                begin
                    div_r_reg <= r_sh;
                    q_reg     <= {q_reg[60:0], 1'b0};
                end
                div_lo_reg <= {div_lo_reg[60:0], 1'b0};
                if (step_reg == '0)
                begin
                    sq_res_reg <= '0;
                    sq_one_reg <= gws_pkg::SQ_ONE_INIT;
                    step_reg   <= gws_pkg::SQRT_LAST_STEP;
                end
                else
                begin
                    step_reg <= step_reg - 1'b1;
                end
            end
            gws_pkg::BS_SQRT:
            begin
                if (q_ext >= sq_try)
                begin
                    q_reg      <= q_reg - sq_try[61:0];
                    sq_res_reg <= {1'b0, sq_res_reg[63:1]} + sq_one_reg;
                end
                else
                begin
                    sq_res_reg <= {1'b0, sq_res_reg[63:1]};
                end
                sq_one_reg <= {2'b00, sq_one_reg[63:2]};
                step_reg   <= step_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Final value: zero for flagged groups, saturated or signed root otherwise
    always_comb
    begin
        if (status_reg != gws_pkg::ST_OK)
        begin
            skew_c = 32'd0;
        end
        else if (sat_reg)
        begin
            skew_c = neg_reg ? gws_pkg::SKEW_NEG_MAX : gws_pkg::SKEW_POS_MAX;
        end
        else
        begin
            skew_c = neg_reg ? 32'd0 - sq_res_reg[31:0] : sq_res_reg[31:0];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result_key_reg <= key_reg;
            skew_reg       <= skew_c;
            status_out_reg <= status_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_key     = result_key_reg;
    assign skewness_value = skew_reg;
    assign status_code    = status_out_reg;

endmodule

/* src/grouped_weighted_skewness.sv */
`timescale 1ns / 1ps

// Grouped weighted skewness.
// Input channel (in_valid / in_stall) takes requests of key, value, weight,
// sorted by key, and a flush request (flush_end) that closes the open group.
// Output channel (out_valid / out_stall) gives one result per closed group:
// the key, the skewness in signed Q16.16 and a status code.
// The front accumulates weighted power sums at one request per cycle, while
// in_stall is low, through two product stages and the accumulator; a closed
// group waits in a two-entry queue. The back works one group at a time
// through a shared one-bit-per-cycle shift-add multiplier, a 62-step long
// division and a 32-step square root.
// When the queue is full and another group closes, in_stall rises until
// the back frees an entry. A stalled result stays in the output register
// while the back keeps working on the next group.
// Reset clears all control state: no group is open and both queue and
// output register are empty.

module grouped_weighted_skewness
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        group_key,
    input  logic signed [15:0] sample_value,
    input  logic [15:0]        repeat_weight,
    input  logic               flush_end,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        result_key,
    output logic signed [31:0] skewness_value,
    output logic [1:0]         status_code
);

    logic              push;
    gws_pkg::snap_t    push_data;
    logic              q_full;
    logic              pop;
    gws_pkg::snap_t    head;
    logic              nonempty;
    gws_pkg::mul_req_t mul_req;
    gws_pkg::mul_rsp_t mul_rsp;
    logic [31:0]       skew_bits;

    gws_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .group_key     (group_key),
        .sample_value  (sample_value),
        .repeat_weight (repeat_weight),
        .flush_end     (flush_end),
        .push          (push),
        .push_data     (push_data),
        .q_full        (q_full)
    );

    gws_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .head      (head),
        .nonempty  (nonempty)
    );

    gws_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    gws_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .nonempty       (nonempty),
        .pop            (pop),
        .mul_req        (mul_req),
        .mul_rsp        (mul_rsp),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_key     (result_key),
        .skewness_value (skew_bits),
        .status_code    (status_code)
    );

    assign skewness_value = $signed(skew_bits);

endmodule

/* verif/grouped_weighted_skewness_tb.sv */
`timescale 1ns / 1ps

module grouped_weighted_skewness_tb;

    typedef logic signed [383:0] exact_t;

    typedef struct {
        logic [31:0]        key;
        logic signed [31:0] skew;
        gws_pkg::status_t   status;
    } skew_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [31:0]        group_key = '0;
    logic signed [15:0] sample_value = '0;
    logic [15:0]        repeat_weight = '0;
    logic               flush_end = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [31:0]        result_key;
    logic signed [31:0] skewness_value;
    logic [1:0]         status_code;

    // shadow of the open group
    logic [31:0]    grp_key;
    bit             grp_open;
    int unsigned    grp_count;
    longint         grp_s1;
    longint         grp_s2;
    longint         grp_s3;
    bit             grp_ovf;

    skew_result_t   pending_skews[$];
    int             mismatch_count = 0;
    int             idle_pct = 0;
    int             sent_count = 0;

    grouped_weighted_skewness i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .group_key      (group_key),
        .sample_value   (sample_value),
        .repeat_weight  (repeat_weight),
        .flush_end      (flush_end),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_key     (result_key),
        .skewness_value (skewness_value),
        .status_code    (status_code)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #30_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic void clear_group();
        grp_key   = '0;
        grp_open  = 1'b0;
        grp_count = 0;
        grp_s1    = 0;
        grp_s2    = 0;
        grp_s3    = 0;
        grp_ovf   = 1'b0;
    endfunction

    // exact skewness of the open group, truncated into Q16.16
    function automatic skew_result_t close_skew();
        skew_result_t r;
        exact_t n, s1, s2, s3, a, b, t, m, num, den;
        bit neg;
        logic [63:0] q, root, cand;
        n  = grp_count;
        s1 = grp_s1;
        s2 = grp_s2;
        s3 = grp_s3;
        a  = n * s2 - s1 * s1;
        r.key = grp_key;
        r.skew = '0;
        if (grp_ovf)
            r.status = gws_pkg::ST_OVF;
        else if (grp_count < 2)
            r.status = gws_pkg::ST_FEW;
        else if (a == 0)
            r.status = gws_pkg::ST_FLAT;
        else
        begin
            r.status = gws_pkg::ST_OK;
            b = n * n * s3 - 3 * n * s1 * s2 + 2 * s1 * s1 * s1;
            neg = b < 0;
            if (neg)
                b = -b;
            t = n - 1;
            num = (b * b * t * t * t) <<< 32;
            m = n * a;
            den = m * m * m;
            if (num >= (den <<< 62))
                r.skew = neg ? gws_pkg::SKEW_NEG_MAX : gws_pkg::SKEW_POS_MAX;
            else
            begin
                q = 64'(num / den);
                root = '0;
                for (int i = 31; i >= 0; i--)
                begin
                    cand = root | (64'd1 << i);
                    if (cand * cand <= q)
                        root = cand;
                end
                r.skew = neg ? -root[31:0] : root[31:0];
            end
        end
        return r;
    endfunction

    // advance the shadow group by one accepted request
    function automatic void predict_request(logic [31:0] key, logic signed [15:0] val,
                                            logic [15:0] wt, logic fl);
        longint x, wx;
        if (fl)
        begin
            if (grp_open)
                pending_skews.push_back(close_skew());
            clear_group();
            return;
        end
        if (!grp_open || key != grp_key)
        begin
            if (grp_open)
                pending_skews.push_back(close_skew());
            clear_group();
            grp_key  = key;
            grp_open = 1'b1;
        end
        x = val;
        if (!grp_ovf)
        begin
            if (grp_count + wt > 65535)
                grp_ovf = 1'b1;
            else
            begin
                grp_count += wt;
                wx = longint'(wt) * x;
                grp_s1 += wx;
                grp_s2 += wx * x;
                grp_s3 += wx * x * x;
            end
        end
    endfunction

    // one request through the input handshake, then a random gap
    task automatic send_request(logic [31:0] key, logic signed [15:0] val,
                                logic [15:0] wt, logic fl);
        int gap;
        in_valid      <= 1'b1;
        group_key     <= key;
        sample_value  <= val;
        repeat_weight <= wt;
        flush_end     <= fl;
        do
            @(posedge clk);
        while (in_stall);
        predict_request(key, val, wt, fl);
        sent_count++;
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct && gap < 6)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_flush();
        send_request($urandom, 16'($urandom), 16'($urandom), 1'b1);
    endtask

    // receiver stalls
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < idle_pct);

    // result checker
    always @(posedge clk)
    begin
        skew_result_t e;
        if (out_valid && !out_stall)
        begin
            if (pending_skews.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result key=%h skew=%h status=%0d",
                             result_key, skewness_value, status_code);
            end
            else
            begin
                e = pending_skews.pop_front();
                if (result_key !== e.key || skewness_value !== e.skew
                    || status_code !== e.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp key=%h skew=%h status=%0d, got key=%h skew=%h status=%0d",
                                 e.key, e.skew, e.status,
                                 result_key, skewness_value, status_code);
                end
            end
        end
    end

    // status flags and extremes of the fields
    task automatic test_status_cases();
        send_flush();                                   // nothing open: no result
        send_request(32'h0, 16'sd5, 16'd1, 1'b0);       // one sample
        send_request(32'hFFFF_FFFF, 16'sd3, 16'd0, 1'b0); // weight zero only
        send_request(32'hFFFF_FFFF, -16'sd9, 16'd1, 1'b0);
        send_flush();
        send_request(32'hFFFF_FFFF, 16'sd7, 16'd5, 1'b0); // same key after flush, flat
        send_request(32'h1, 16'sh7FFF, 16'hFFFF, 1'b0);  // full count, flat
        send_request(32'h2, 16'sh8000, 16'd40000, 1'b0); // overflow
        send_request(32'h2, 16'sd1, 16'd30000, 1'b0);
        send_request(32'h2, 16'sd1, 16'd2, 1'b0);
        send_request(32'h3, 16'sh7FFF, 16'd1, 1'b0);     // strong positive skew
        send_request(32'h3, 16'sh8000, 16'd65534, 1'b0);
        send_request(32'h4, 16'sh8000, 16'd1, 1'b0);     // strong negative skew
        send_request(32'h4, 16'sh7FFF, 16'd100, 1'b0);
        send_request(32'h5, -16'sd1, 16'd3, 1'b0);       // ordinary mix
        send_request(32'h5, 16'sd4, 16'd2, 1'b0);
        send_request(32'h5, 16'sd10, 16'd1, 1'b0);
        send_request(32'h5, 16'sh5555, 16'hAAAA, 1'b0);
        send_flush();
        send_flush();
    endtask

    // random groups: mostly well formed, some noise
    task automatic test_random_groups(int n_items);
        logic [31:0] key;
        logic signed [15:0] base, val;
        logic [15:0] wt;
        int len, vmode, wmode;
        key = $urandom;
        while (sent_count < n_items)
        begin
            if (sent_count > 350)
                idle_pct = 18;
            case ($urandom_range(0, 9))
                0:       key = $urandom;
                1:       key = key;
                default: key = key + $urandom_range(1, 3);
            endcase
            len   = $urandom_range(1, 8);
            vmode = $urandom_range(0, 3);
            wmode = $urandom_range(0, 9);
            base  = 16'($urandom);
            for (int i = 0; i < len; i++)
            begin
                case (vmode)
                    0: val = 16'($urandom);
                    1: val = 16'($signed($urandom_range(0, 40)) - 20);
                    2: val = base;
                    default: val = base + 16'($urandom_range(0, 3));
                endcase
                if (wmode == 0)
                    wt = 16'($urandom);
                else if (wmode == 1)
                    wt = 16'($urandom_range(0, 2));
                else
                    wt = 16'($urandom_range(1, 20));
                send_request(key, val, wt, 1'b0);
            end
            if ($urandom_range(0, 4) == 0)
                send_flush();
            if ($urandom_range(0, 19) == 0)
                send_flush();
        end
        send_flush();
    endtask

    initial
    begin
        clear_group();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_status_cases();
        test_random_groups(1100);
        in_valid <= 1'b0;
        while (pending_skews.size() != 0)
            @(posedge clk);
        repeat (700) @(posedge clk);
        if (mismatch_count == 0 && pending_skews.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* filelist.f */
src/gws_pkg.sv
src/gws_front.sv
src/gws_queue.sv
src/gws_mul.sv
src/gws_back.sv
src/grouped_weighted_skewness.sv
verif/grouped_weighted_skewness_tb.sv
